/* hw/rtl/vn4_pkg.sv */
// Shared types and constants for the four-dimensional value noise block.
// Holds the item selector codes, the table read levels, the controller
// states and the command and status groups between controller and datapath.
`default_nettype none

package vn4_pkg;

    // Default table depth, a power of two
    localparam int TABLE_SIZE_DEF = 256;

    // Item selector codes carried on tuser
    localparam logic [1:0] FUNC_LOAD_PERM  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_NOISE = 2'd1;
    localparam logic [1:0] FUNC_EVAL       = 2'd2;

    // Which coordinate a permutation read belongs to
    typedef enum logic [1:0] {
        RD_LVL_T,
        RD_LVL_Z,
        RD_LVL_Y,
        RD_LVL_X
    } rd_lvl_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_T,
        ST_RD_Z,
        ST_RD_Y,
        ST_RD_X,
        ST_RD_N,
        ST_DRAIN
    } ctl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       wr_perm;
        logic       wr_noise;
        logic       eval_start;
        logic       rd_perm;
        rd_lvl_t    rd_lvl;
        logic       rd_noise;
        logic [3:0] corner;
        logic       out_load;
    } vn4_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fin;
        logic out_free;
    } vn4_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/value_noise_4d.sv */
// Four-dimensional value noise. Load items (tuser 0, 1) write one entry of
// the permutation table or the noise table in the cycle they transfer and
// give no result; tuser 3 is dropped. An evaluate item (tuser 2) looks up
// the 16 corners of its lattice cell through chained permutation reads and
// blends them with 15 linear interpolations into one Q1.15 result. The
// block takes one item at a time: a load never holds off the next item; an
// evaluate holds it off through its 30 permutation and 16 noise reads,
// which run one after another through the table memories (each read
// address depends on the previous read), and the last four blends of
// the two-stage lerp unit. A finished result waits in an output register, so
// the next item may transfer before the result is taken. Tables are not
// cleared at reset; read only entries that have been written.
`default_nettype none

module value_noise_4d #(
    parameter int TABLE_SIZE = vn4_pkg::TABLE_SIZE_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // load_index[7:0], perm_value[15:8], table_value[31:16], coord_x[63:32],
    // coord_y[95:64], coord_z[127:96], coord_t[159:128]
    input  wire logic [159:0]  s_tdata,
    // func[1:0]
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // noise[15:0]
    output logic [15:0]        m_tdata
);

    vn4_pkg::vn4_cmd_t  cmd;
    vn4_pkg::vn4_sts_t  sts;
    logic signed [15:0] noise;

    vn4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    vn4_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .load_index  (s_tdata[7:0]),
        .perm_value  (s_tdata[15:8]),
        .table_value ($signed(s_tdata[31:16])),
        .coord_x     ($signed(s_tdata[63:32])),
        .coord_y     ($signed(s_tdata[95:64])),
        .coord_z     ($signed(s_tdata[127:96])),
        .coord_t     ($signed(s_tdata[159:128])),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (noise)
    );

    assign m_tdata = noise;

endmodule

`default_nettype wire

/* hw/rtl/vn4_ctrl.sv */
// Sequencer for the value noise block: accepts items and walks the 16 cell
// corners through the chain of table reads. Uses vn4_pkg for states and
// the command and status groups.
`default_nettype none

module vn4_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [1:0]          s_tuser,   // func
    input  wire vn4_pkg::vn4_sts_t   sts,
    output vn4_pkg::vn4_cmd_t        cmd
);

    localparam logic [3:0] CORNER_LAST = 4'hF;

    vn4_pkg::ctl_state_t state_reg, state_next;
    logic [3:0]          corner_reg, corner_next;
    logic [3:0]          corner_inc;
    logic [3:0]          corner_chg;
    logic                accept;

    assign s_tready   = (state_reg == vn4_pkg::ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign corner_inc = corner_reg + 4'd1;
    assign corner_chg = corner_reg ^ corner_inc;

    // Hold state and corner count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= vn4_pkg::ST_IDLE;
            corner_reg <= '0;
        end else begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    // Next state: restart the read chain at the highest coordinate that changes
    always_comb begin
        state_next  = state_reg;
        corner_next = corner_reg;
        unique case (state_reg)
            vn4_pkg::ST_IDLE: begin
                if (accept && (s_tuser == vn4_pkg::FUNC_EVAL)) begin
                    state_next  = vn4_pkg::ST_RD_T;
                    corner_next = '0;
                end
            end
            vn4_pkg::ST_RD_T: state_next = vn4_pkg::ST_RD_Z;
            vn4_pkg::ST_RD_Z: state_next = vn4_pkg::ST_RD_Y;
            vn4_pkg::ST_RD_Y: state_next = vn4_pkg::ST_RD_X;
            vn4_pkg::ST_RD_X: state_next = vn4_pkg::ST_RD_N;
            vn4_pkg::ST_RD_N: begin
                if (corner_reg == CORNER_LAST) begin
                    state_next = vn4_pkg::ST_DRAIN;
                end else begin
                    corner_next = corner_inc;
                    priority if (corner_chg[3]) state_next = vn4_pkg::ST_RD_T;
                    else if (corner_chg[2])     state_next = vn4_pkg::ST_RD_Z;
                    else if (corner_chg[1])     state_next = vn4_pkg::ST_RD_Y;
                    else                        state_next = vn4_pkg::ST_RD_X;
                end
            end
            vn4_pkg::ST_DRAIN: begin
                if (sts.fin && sts.out_free) begin
                    state_next = vn4_pkg::ST_IDLE;
                end
            end
            default: state_next = vn4_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd.wr_perm    = accept && (s_tuser == vn4_pkg::FUNC_LOAD_PERM);
        cmd.wr_noise   = accept && (s_tuser == vn4_pkg::FUNC_LOAD_NOISE);
        cmd.eval_start = accept && (s_tuser == vn4_pkg::FUNC_EVAL);
        cmd.rd_perm    = 1'b0;
        cmd.rd_lvl     = vn4_pkg::RD_LVL_T;
        cmd.rd_noise   = 1'b0;
        cmd.corner     = corner_reg;
        cmd.out_load   = 1'b0;
        unique case (state_reg)
            vn4_pkg::ST_RD_T: begin
                cmd.rd_perm = 1'b1;
                cmd.rd_lvl  = vn4_pkg::RD_LVL_T;
            end
            vn4_pkg::ST_RD_Z: begin
                cmd.rd_perm = 1'b1;
                cmd.rd_lvl  = vn4_pkg::RD_LVL_Z;
            end
            vn4_pkg::ST_RD_Y: begin
                cmd.rd_perm = 1'b1;
                cmd.rd_lvl  = vn4_pkg::RD_LVL_Y;
            end
            vn4_pkg::ST_RD_X: begin
                cmd.rd_perm = 1'b1;
                cmd.rd_lvl  = vn4_pkg::RD_LVL_X;
            end
            vn4_pkg::ST_RD_N: cmd.rd_noise = 1'b1;
            vn4_pkg::ST_DRAIN: cmd.out_load = sts.fin && sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/vn4_dp.sv */
// Datapath for the value noise block: the two table memories, the address
// chain, the corner stack, the shared lerp unit and the result register.
// Driven by vn4_ctrl through the command group of vn4_pkg.
`default_nettype none

module vn4_dp #(
    parameter int TABLE_SIZE = vn4_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire vn4_pkg::vn4_cmd_t   cmd,
    output vn4_pkg::vn4_sts_t        sts,
    input  wire logic [7:0]          load_index,
    input  wire logic [7:0]          perm_value,
    input  wire logic signed [15:0]  table_value,
    input  wire logic signed [31:0]  coord_x,
    input  wire logic signed [31:0]  coord_y,
    input  wire logic signed [31:0]  coord_z,
    input  wire logic signed [31:0]  coord_t,
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    output logic signed [15:0]       m_tdata
);

    localparam int ADDR_W = $clog2(TABLE_SIZE);

    // Blend levels: a value at level L waits for its partner along axis L
    localparam logic [2:0] BL_Y    = 3'd1;
    localparam logic [2:0] BL_Z    = 3'd2;
    localparam logic [2:0] BL_T    = 3'd3;
    localparam logic [2:0] BL_DONE = 3'd4;

    // Table memories
    logic [7:0]  perm_mem  [TABLE_SIZE];
    logic [15:0] noise_mem [TABLE_SIZE];

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] noise_addr;
    logic [7:0]        perm_q;
    logic signed [15:0] noise_q;

    // Captured coordinates
    logic [ADDR_W-1:0] ix_reg, iy_reg, iz_reg, it_reg;
    logic [15:0]       fx_reg, fy_reg, fz_reg, ft_reg;

    // Last permutation read and saved chain values
    logic              rt_valid_reg;
    vn4_pkg::rd_lvl_t  rt_lvl_reg;
    logic [7:0]        pt_reg, pz_reg, py_reg;
    logic [ADDR_W-1:0] base_z, base_y, base_x;

    // Noise read tag
    logic              nq_valid_reg;
    logic [3:0]        nq_c_reg;

    // Corner stack
    logic signed [15:0] stk_x_reg, stk_y_reg, stk_z_reg, stk_t_reg;

    // Lerp unit
    logic               nz_start, cas_start, lerp_start;
    logic signed [15:0] la, lb;
    logic [15:0]        lf;
    logic [2:0]         l_lvl;
    logic [3:0]         l_c;
    logic signed [16:0] l_diff;
    logic signed [33:0] l_prod;
    logic               ls_valid_reg;
    logic signed [33:0] ls_prod_reg;
    logic signed [15:0] ls_a_reg;
    logic [2:0]         ls_lvl_reg;
    logic [3:0]         ls_c_reg;
    logic [17:0]        ls_sum;
    logic               lr_valid_reg;
    logic signed [15:0] lr_res_reg;
    logic [2:0]         lr_lvl_reg;
    logic [3:0]         lr_c_reg;
    logic signed [15:0] cas_a;
    logic [15:0]        cas_f;

    // Result hand-off
    logic               fin_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_data_reg;

    assign wr_addr    = ADDR_W'(load_index);
    assign noise_addr = ADDR_W'(perm_q);

    // Take the fresh read when the level above was read last cycle
    assign base_z = (rt_valid_reg && rt_lvl_reg == vn4_pkg::RD_LVL_T) ?
                    ADDR_W'(perm_q) : ADDR_W'(pt_reg);
    assign base_y = (rt_valid_reg && rt_lvl_reg == vn4_pkg::RD_LVL_Z) ?
                    ADDR_W'(perm_q) : ADDR_W'(pz_reg);
    assign base_x = (rt_valid_reg && rt_lvl_reg == vn4_pkg::RD_LVL_Y) ?
                    ADDR_W'(perm_q) : ADDR_W'(py_reg);

    // Permutation address for the current level, wrapping at the table size
    always_comb begin
        unique case (cmd.rd_lvl)
            vn4_pkg::RD_LVL_T: rd_addr = it_reg + ADDR_W'(cmd.corner[3]);
            vn4_pkg::RD_LVL_Z: rd_addr = iz_reg + ADDR_W'(cmd.corner[2]) + base_z;
            vn4_pkg::RD_LVL_Y: rd_addr = iy_reg + ADDR_W'(cmd.corner[1]) + base_y;
            vn4_pkg::RD_LVL_X: rd_addr = ix_reg + ADDR_W'(cmd.corner[0]) + base_x;
            default:           rd_addr = it_reg;
        endcase
    end

    // Permutation table: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_perm) begin
            perm_mem[wr_addr] <= perm_value;
        end
        if (cmd.rd_perm) begin
            perm_q <= perm_mem[rd_addr];
        end
    end

    // Noise table: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_noise) begin
            noise_mem[wr_addr] <= table_value;
        end
        if (cmd.rd_noise) begin
            noise_q <= noise_mem[noise_addr];
        end
    end

    // Capture lattice coordinates and fractions
    always_ff @(posedge aclk) begin
        if (cmd.eval_start) begin
            ix_reg <= ADDR_W'(coord_x[31:16]);
            iy_reg <= ADDR_W'(coord_y[31:16]);
            iz_reg <= ADDR_W'(coord_z[31:16]);
            it_reg <= ADDR_W'(coord_t[31:16]);
            fx_reg <= coord_x[15:0];
            fy_reg <= coord_y[15:0];
            fz_reg <= coord_z[15:0];
            ft_reg <= coord_t[15:0];
        end
    end

    // Save each permutation result for reuse by later corners
    always_ff @(posedge aclk) begin
        if (rt_valid_reg) begin
            unique case (rt_lvl_reg)
                vn4_pkg::RD_LVL_T: pt_reg <= perm_q;
                vn4_pkg::RD_LVL_Z: pz_reg <= perm_q;
                vn4_pkg::RD_LVL_Y: py_reg <= perm_q;
                default: ;
            endcase
        end
    end

    // Lerp start: an odd corner from the noise table, or a cascaded result
    assign nz_start  = nq_valid_reg && nq_c_reg[0];
    assign cas_start = lr_valid_reg && (lr_lvl_reg != BL_DONE) &&
                       lr_c_reg[lr_lvl_reg[1:0]];
    assign lerp_start = nz_start || cas_start;

    always_comb begin
        unique case (lr_lvl_reg[1:0])
            BL_Y[1:0]: begin
                cas_a = stk_y_reg;
                cas_f = fy_reg;
            end
            BL_Z[1:0]: begin
                cas_a = stk_z_reg;
                cas_f = fz_reg;
            end
            BL_T[1:0]: begin
                cas_a = stk_t_reg;
                cas_f = ft_reg;
            end
            default: begin
                cas_a = stk_x_reg;
                cas_f = fx_reg;
            end
        endcase
    end

    always_comb begin
        if (nz_start) begin
            la    = stk_x_reg;
            lb    = noise_q;
            lf    = fx_reg;
            l_lvl = BL_Y;
            l_c   = nq_c_reg;
        end else begin
            la    = cas_a;
            lb    = lr_res_reg;
            lf    = cas_f;
            l_lvl = lr_lvl_reg + 3'd1;
            l_c   = lr_c_reg;
        end
    end

    // Stage one multiplies the difference by the fraction
    assign l_diff = $signed({lb[15], lb}) - $signed({la[15], la});
    assign l_prod = $signed({{17{l_diff[16]}}, l_diff}) * $signed({18'd0, lf});
    // Stage two adds the floored quotient back to the lower operand
    assign ls_sum = {{2{ls_a_reg[15]}}, ls_a_reg} + ls_prod_reg[33:16];

    always_ff @(posedge aclk) begin
        if (lerp_start) begin
            ls_prod_reg <= l_prod;
            ls_a_reg    <= la;
            ls_lvl_reg  <= l_lvl;
            ls_c_reg    <= l_c;
        end
        if (ls_valid_reg) begin
            lr_res_reg <= ls_sum[15:0];
            lr_lvl_reg <= ls_lvl_reg;
            lr_c_reg   <= ls_c_reg;
        end
        if (cmd.rd_noise) begin
            nq_c_reg <= cmd.corner;
        end
        if (cmd.rd_perm) begin
            rt_lvl_reg <= cmd.rd_lvl;
        end
        if (cmd.out_load) begin
            out_data_reg <= lr_res_reg;
        end
    end

    // Park the first of each pair on the stack
    always_ff @(posedge aclk) begin
        if (nq_valid_reg && !nq_c_reg[0]) begin
            stk_x_reg <= noise_q;
        end
        if (lr_valid_reg && !lr_c_reg[lr_lvl_reg[1:0]]) begin
            unique case (lr_lvl_reg)
                BL_Y: stk_y_reg <= lr_res_reg;
                BL_Z: stk_z_reg <= lr_res_reg;
                BL_T: stk_t_reg <= lr_res_reg;
                default: ;
            endcase
        end
    end

    // Valid flags and the output register handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_valid_reg  <= 1'b0;
            nq_valid_reg  <= 1'b0;
            ls_valid_reg  <= 1'b0;
            lr_valid_reg  <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rt_valid_reg <= cmd.rd_perm;
            nq_valid_reg <= cmd.rd_noise;
            ls_valid_reg <= lerp_start;
            lr_valid_reg <= ls_valid_reg;
            if (cmd.out_load) begin
                fin_reg <= 1'b0;
            end else if (lr_valid_reg && lr_lvl_reg == BL_DONE) begin
                fin_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.fin      = fin_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;

    // A noise read follows directly on the x permutation read
    a_noise_after_x: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_noise |-> (rt_valid_reg && rt_lvl_reg == vn4_pkg::RD_LVL_X))
        else $error("noise read without a preceding x permutation read");

    // The shared lerp unit never gets two starts in one cycle
    a_one_lerp: assert property (@(posedge aclk) disable iff (!aresetn)
        !(nz_start && cas_start))
        else $error("lerp unit claimed twice in one cycle");

    // The final blend comes only from the last corner
    a_final_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        (lr_valid_reg && lr_lvl_reg == BL_DONE) |-> (lr_c_reg == 4'hF))
        else $error("final blend from a corner other than the last");

    // A result is loaded only when ready and never over one still waiting
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (fin_reg && (!out_valid_reg || m_tready)))
        else $error("result register overwritten or loaded early");

endmodule

`default_nettype wire

/* bench/tb_value_noise_4d.sv */
// Self-checking bench for value_noise_4d: streams table loads and evaluate items,
// predicts results from a mirror of the tables or takes them from directed rows,
// and checks each transfer. Depends on vn4_pkg and value_noise_4d only.

module tb_value_noise_4d;

    localparam int          TBL          = vn4_pkg::TABLE_SIZE_DEF;
    localparam logic [1:0]  FUNC_SPARE   = 2'd3;
    localparam logic [15:0] NOISE_HI     = 16'h7FFF;
    localparam logic [15:0] NOISE_LO     = 16'h8000;
    localparam int          ITEMS_RANDOM = 320;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          TAIL_CYCLES  = 120;
    localparam longint      WATCHDOG     = 64'd5_000_000;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

    typedef struct {
        logic [1:0]  fn;
        logic [7:0]  idx;
        logic [7:0]  pv;
        logic [15:0] nv;
        logic [31:0] cx, cy, cz, ct;
        bit          typed;
        logic [15:0] want;
    } probe_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;

    // Mirror of the block's tables and the results still owed
    logic [7:0]        perm_mirror  [TBL];
    logic signed [15:0] noise_mirror [TBL];
    logic [15:0]       noise_due [$];

    // Directed stimulus table
    probe_t rows [$];

    int mismatches, n_checked, n_perm, n_noise, n_evals, n_dropped;
    int burst_left, random_items;
    bit hold_req;
    int hold_left, rx_left, rx_phase;
    rx_mode_t rx_mode;

    value_noise_4d dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(WATCHDOG);
        $display("tb_value_noise_4d failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned perm_of(int unsigned a);
        return perm_mirror[a % TBL];
    endfunction

    function automatic int lattice_value(int unsigned x, int unsigned y, int unsigned z,
                                         int unsigned t);
        int unsigned k;
        k = perm_of(x + perm_of(y + perm_of(z + perm_of(t))));
        return noise_mirror[k % TBL];
    endfunction

    // a + floor((b - a) * f / 2^16); the arithmetic shift floors
    function automatic int lerp16(int a, int b, int f);
        longint prod;
        prod = longint'(b - a) * longint'(f);
        return a + int'(prod >>> 16);
    endfunction

    function automatic logic [15:0] noise_at(logic [31:0] cx, logic [31:0] cy,
                                             logic [31:0] cz, logic [31:0] ct);
        int unsigned ix, iy, iz, it, tt;
        int fx, fy, fz, ft, e0, e1, e2, e3, fv, bv, ret;
        int slab [2];
        ix = cx[31:16]; iy = cy[31:16]; iz = cz[31:16]; it = ct[31:16];
        fx = cx[15:0];  fy = cy[15:0];  fz = cz[15:0];  ft = ct[15:0];
        // blend x, then y, then z within each t slice
        for (int i = 0; i < 2; i++) begin
            tt = it + i;
            e0 = lerp16(lattice_value(ix, iy, iz, tt), lattice_value(ix + 1, iy, iz, tt), fx);
            e1 = lerp16(lattice_value(ix, iy + 1, iz, tt),
                        lattice_value(ix + 1, iy + 1, iz, tt), fx);
            e2 = lerp16(lattice_value(ix, iy, iz + 1, tt),
                        lattice_value(ix + 1, iy, iz + 1, tt), fx);
            e3 = lerp16(lattice_value(ix, iy + 1, iz + 1, tt),
                        lattice_value(ix + 1, iy + 1, iz + 1, tt), fx);
            fv = lerp16(e0, e1, fy);
            bv = lerp16(e2, e3, fy);
            slab[i] = lerp16(fv, bv, fz);
        end
        ret = lerp16(slab[0], slab[1], ft);
        return ret[15:0];
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
        mismatches++;
    endtask

    // Compare each result transfer with the oldest owed value
    always @(posedge aclk) begin : take_result
        logic [15:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (noise_due.size() == 0) begin
                report_mismatch("result with none pending", 'x, m_tdata);
            end else begin
                want = noise_due.pop_front();
                n_checked++;
                if (m_tdata !== want)
                    report_mismatch("noise", want, m_tdata);
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Stall on a changing pattern; a requested hold-off overrides it
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 5) == 0);
                default:   m_tready <= (rx_phase % 7) < 3;
            endcase
        end
    end

    // ---------------------------------------------------------------- sender

    // Bursts of random length separated by random gaps, sometimes none
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
    endtask

    // Offer one item, hold it until the transfer, then update the mirror
    task automatic send_item(input logic [1:0] fn, input logic [159:0] data,
                             input bit typed, input logic [15:0] want);
        pace();
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (fn)
            vn4_pkg::FUNC_LOAD_PERM: begin
                perm_mirror[data[7:0] % TBL] = data[15:8];
                n_perm++;
            end
            vn4_pkg::FUNC_LOAD_NOISE: begin
                noise_mirror[data[7:0] % TBL] = data[31:16];
                n_noise++;
            end
            vn4_pkg::FUNC_EVAL: begin
                noise_due.insert(noise_due.size(), typed ? want
                    : noise_at(data[63:32], data[95:64], data[127:96], data[159:128]));
                n_evals++;
            end
            default: n_dropped++;
        endcase
    endtask

    // Stop offering and wait until every owed result has arrived
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (noise_due.size() != 0);
    endtask

    function automatic logic [159:0] scramble();
        return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    function automatic logic [7:0] pick_index();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_noise();
        case ($urandom_range(0, 7))
            0:       return NOISE_HI;
            1:       return NOISE_LO;
            2:       return 16'($urandom_range(0, 31) - 16);
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Mix of full-range, near-origin, integral, edge-of-cell and boundary coordinates
    function automatic logic [31:0] pick_coord();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2: return r;
            3, 4:    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            5:       return {r[15:0], 16'h0000};
            6:       return {r[15:0], 16'hFFFF};
            7: begin
                case ($urandom_range(0, 4))
                    0:       return {16'hFFFF, r[15:0]};
                    1:       return {16'h0000, r[15:0]};
                    2:       return {16'h7FFF, r[15:0]};
                    3:       return {16'h8000, r[15:0]};
                    default: return {16'h00FF, r[15:0]};
                endcase
            end
            default: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h0000_0000;
                    4:       return 32'hFFFF_0000;
                    default: return 32'h0000_FFFF;
                endcase
            end
        endcase
    endfunction

    task automatic send_rand_load();
        logic [159:0] d;
        d = scramble();
        d[7:0] = pick_index();
        d[31:16] = pick_noise();
        send_item($urandom_range(0, 1) ? vn4_pkg::FUNC_LOAD_NOISE : vn4_pkg::FUNC_LOAD_PERM,
                  d, 1'b0, '0);
        random_items++;
    endtask

    task automatic send_rand_eval();
        logic [159:0] d;
        d = scramble();
        d[159:32] = {pick_coord(), pick_coord(), pick_coord(), pick_coord()};
        send_item(vn4_pkg::FUNC_EVAL, d, 1'b0, '0);
        random_items++;
    endtask

    // Append one row to the directed table
    task automatic add_row(input logic [1:0] fn, input logic [7:0] idx, input logic [7:0] pv,
                           input logic [15:0] nv, input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] cz, input logic [31:0] ct, input bit typed,
                           input logic [15:0] want);
        probe_t p;
        p.fn = fn; p.idx = idx; p.pv = pv; p.nv = nv;
        p.cx = cx; p.cy = cy; p.cz = cz; p.ct = ct;
        p.typed = typed; p.want = want;
        rows.insert(rows.size(), p);
    endtask

    // ---------------------------------------------------------------- main flow

    initial begin
        logic [159:0] d;
        bit held, paused;
        int pick;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill both tables: random permutation entries, every noise value at maximum
        for (int k = 0; k < TBL; k++) begin
            d = scramble();
            d[7:0] = 8'(k);
            d[15:8] = 8'($urandom_range(0, 255));
            send_item(vn4_pkg::FUNC_LOAD_PERM, d, 1'b0, '0);
        end
        for (int k = 0; k < TBL; k++) begin
            d = scramble();
            d[7:0] = 8'(k);
            d[31:16] = NOISE_HI;
            send_item(vn4_pkg::FUNC_LOAD_NOISE, d, 1'b0, '0);
        end

        // Directed rows; a flat noise table gives the same value at any coordinate
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 0, 0, 0, 0, 1, NOISE_HI);
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, NOISE_HI);
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 1, NOISE_HI);
        add_row(vn4_pkg::FUNC_EVAL, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, NOISE_HI);
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 32'h0000_FFFF, 32'h0000_8000,
                32'hFFFF_0001, 32'h7FFF_0000, 1, NOISE_HI);
        add_row(vn4_pkg::FUNC_LOAD_NOISE, 8'h00, 8'hFF, NOISE_LO, 0, 0, 0, 0, 0, 0);
        add_row(vn4_pkg::FUNC_LOAD_NOISE, 8'hFF, 8'h00, NOISE_HI, '1, '1, '1, '1, 0, 0);
        add_row(vn4_pkg::FUNC_LOAD_PERM, 8'h00, 8'h00, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        add_row(vn4_pkg::FUNC_LOAD_PERM, 8'hFF, 8'hFF, 16'h0000, '1, '1, '1, '1, 0, 0);
        add_row(vn4_pkg::FUNC_LOAD_PERM, 8'h01, 8'hFF, 16'h0000, 0, 0, 0, 0, 0, 0);
        // origin with zero fractions gives the single corner value noise[perm[0]]
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 0, 0, 0, 0, 1, NOISE_LO);
        // spare selector must leave both tables alone
        add_row(FUNC_SPARE, 8'h00, 8'hAA, 16'h1234, '1, '1, '1, '1, 0, 0);
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 0, 0, 0, 0, 1, NOISE_LO);
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 32'h0000_FFFF, 0, 0, 0, 0, 0);
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 32'h0000_8000, 32'h0000_8000,
                32'h0000_8000, 32'h0000_8000, 0, 0);
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_FFFF,
                32'hFFFF_8000, 32'h0001_FFFF, 0, 0);
        add_row(vn4_pkg::FUNC_LOAD_NOISE, 8'h01, 8'h00, 16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(vn4_pkg::FUNC_LOAD_PERM, 8'h80, 8'h01, 16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 32'h8000_FFFF, 32'h7FFF_0000,
                32'h0000_0001, 32'hFFFF_FFFF, 0, 0);
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 32'hFFFF_0000, 32'hFFFF_0000,
                32'hFFFF_0000, 32'hFFFF_0000, 0, 0);
        add_row(vn4_pkg::FUNC_LOAD_NOISE, 8'hFE, 8'h00, 16'h0001, 0, 0, 0, 0, 0, 0);
        add_row(vn4_pkg::FUNC_EVAL, 0, 0, 0, 32'h00FE_C000, 32'h00FF_4000,
                32'h0001_0000, 32'h8001_7FFF, 0, 0);
        foreach (rows[i])
            send_item(rows[i].fn, {rows[i].ct, rows[i].cz, rows[i].cy, rows[i].cx,
                                   rows[i].nv, rows[i].pv, rows[i].idx},
                      rows[i].typed, rows[i].want);

        // Mostly load-then-evaluate sequences, with spare items and load bursts between
        while (random_items < ITEMS_RANDOM) begin
            if (!held && random_items >= 110) begin
                held = 1'b1;
                hold_req = 1'b1;
                repeat (4) send_rand_eval();
                continue;
            end
            if (!paused && random_items >= 220) begin
                paused = 1'b1;
                wait_idle();
            end
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                repeat ($urandom_range(0, 4)) send_rand_load();
                repeat ($urandom_range(1, 3)) send_rand_eval();
            end else if (pick < 90) begin
                send_item(FUNC_SPARE, scramble(), 1'b0, '0);
            end else begin
                repeat ($urandom_range(2, 6)) send_rand_load();
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run: %0d permutation loads, %0d noise loads, %0d evaluations, %0d spare items",
                 n_perm, n_noise, n_evals, n_dropped);
        $display("Checked %0d results with %0d mismatches, one %0d-cycle output hold-off",
                 n_checked, mismatches, HOLD_CYCLES);
        if (mismatches == 0)
            $display("tb_value_noise_4d passed");
        else
            $display("tb_value_noise_4d failed");
        $finish;
    end

endmodule
